// ===== design/ctc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ctc_pkg;

   localparam int CLASS_W            = 8;
   localparam int NUM_CLASSES_DEF    = 64;
   localparam int PROB_FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH        = 4;

   // One closed timestep as handed from the front part to the back part.
   typedef struct packed {
      logic               c0_en;
      logic               c1_en;
      logic               c1_mul;
      logic               fin;
      logic               empty;
      logic [CLASS_W-1:0] c0_class;
      logic [CLASS_W-1:0] c1_class;
   } step_ctrl_type;

endpackage

`default_nettype wire

// ===== design/ctc_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ctc_req_if #(
   parameter int PROB_W = ctc_pkg::PROB_FRAC_BITS_DEF + 1
);
   logic              valid;
   logic              ready;
   logic [PROB_W-1:0] class_prob;
   logic              last_class;
   logic              last_step;

   modport source (output valid, output class_prob, output last_class, output last_step,
                   input ready);
   modport sink   (input valid, input class_prob, input last_class, input last_step,
                   output ready);
endinterface

interface ctc_rsp_if #(
   parameter int PROB_W = ctc_pkg::PROB_FRAC_BITS_DEF + 1
);
   logic                        valid;
   logic                        ready;
   logic [ctc_pkg::CLASS_W-1:0] char_class;
   logic                        is_end;
   logic [PROB_W-1:0]           confidence;
   logic                        label_empty;

   modport source (output valid, output char_class, output is_end, output confidence,
                   output label_empty, input ready);
   modport sink   (input valid, input char_class, input is_end, input confidence,
                   input label_empty, output ready);
endinterface

interface ctc_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ctc_pkg::CLASS_W-1:0] blank_class;

   modport source (output valid, output blank_class, input ready);
   modport sink   (input valid, input blank_class, output ready);
endinterface

`default_nettype wire

// ===== design/ctc_greedy_decoder.sv =====
// A closing request that pushes an entry writes it into the queue on acceptance; the entry's
// first response is loaded into the response register once the entry heads the queue and that
// register is free. Throughput: one request per cycle while the queue is not full; the response
// register sends one response per cycle while the receiver is ready, up to three per entry.
// A four-entry queue of closed timesteps lies between request and response sides.
// Reset is synchronous and clears the sequence state and sets the blank class to zero.
// A write of the blank class restarts the current sequence.
`timescale 1ns / 1ps
`default_nettype none

module ctc_greedy_decoder #(
   parameter int NUM_CLASSES    = ctc_pkg::NUM_CLASSES_DEF,
   parameter int PROB_FRAC_BITS = ctc_pkg::PROB_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ctc_req_if.sink    req_bus,
   ctc_rsp_if.source  rsp_bus,
   ctc_csr_if.sink    csr_bus
);
   import ctc_pkg::*;

   localparam int PW = PROB_FRAC_BITS + 1;
   localparam int QW = $bits(step_ctrl_type) + 2 * PW;

   logic          clear;
   logic          push, pop, q_full, q_empty;
   step_ctrl_type push_ctrl, head_ctrl;
   logic [PW-1:0] push_c0_prob, push_c1_prob, head_c0_prob, head_c1_prob;
   logic [QW-1:0] push_data, pop_data;

   ctc_front #(
      .NUM_CLASSES    (NUM_CLASSES),
      .PROB_FRAC_BITS (PROB_FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .csr_bus      (csr_bus),
      .q_full       (q_full),
      .push         (push),
      .push_ctrl    (push_ctrl),
      .push_c0_prob (push_c0_prob),
      .push_c1_prob (push_c1_prob),
      .clear        (clear)
   );

   assign push_data = {push_ctrl, push_c0_prob, push_c1_prob};
   assign {head_ctrl, head_c0_prob, head_c1_prob} = pop_data;

   ctc_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   ctc_back #(
      .PROB_FRAC_BITS (PROB_FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .clear        (clear),
      .q_empty      (q_empty),
      .head_ctrl    (head_ctrl),
      .head_c0_prob (head_c0_prob),
      .head_c1_prob (head_c1_prob),
      .pop          (pop),
      .rsp_bus      (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== design/ctc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctc_front #(
   parameter int NUM_CLASSES    = ctc_pkg::NUM_CLASSES_DEF,
   parameter int PROB_FRAC_BITS = ctc_pkg::PROB_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ctc_req_if.sink               req_bus,
   ctc_csr_if.sink               csr_bus,
   input  logic                  q_full,
   output logic                  push,
   output ctc_pkg::step_ctrl_type push_ctrl,
   output logic [PROB_FRAC_BITS:0] push_c0_prob,
   output logic [PROB_FRAC_BITS:0] push_c1_prob,
   output logic                  clear
);
   import ctc_pkg::*;

   localparam int PW = PROB_FRAC_BITS + 1;
   localparam int CW = $clog2(NUM_CLASSES);
   localparam logic [PW-1:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};
   localparam logic [CW-1:0] CNT_MAX  = CW'(NUM_CLASSES - 1);

   logic [CLASS_W-1:0] blank_ff;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [PW-1:0]      best_prob_ff, best_prob_in;
   logic [CW-1:0]      best_class_ff, best_class_in;
   logic [CLASS_W-1:0] run_class_ff, run_class_in;
   logic [PW-1:0]      run_prob_ff, run_prob_in;
   logic               emitted_ff, emitted_in;

   logic               accept;
   logic [PW-1:0]      p_sat;
   logic               upd;
   logic [PW-1:0]      nb_prob;
   logic [CW-1:0]      nb_class;
   logic [CLASS_W-1:0] nb_class_w;
   logic [CLASS_W-1:0] new_run_class;
   logic [PW-1:0]      new_run_prob;
   logic               emitted;
   step_ctrl_type      ctrl;

   assign req_bus.ready = !q_full;
   assign csr_bus.ready = 1'b1;
   assign accept        = req_bus.valid && req_bus.ready;
   assign clear         = csr_bus.valid;

   assign p_sat      = (req_bus.class_prob > PROB_ONE) ? PROB_ONE : req_bus.class_prob;
   assign upd        = best_prob_ff < p_sat;
   assign nb_prob    = upd ? p_sat : best_prob_ff;
   assign nb_class   = upd ? cnt_ff : best_class_ff;
   assign nb_class_w = CLASS_W'(nb_class);

   always_comb begin
      cnt_in        = cnt_ff;
      best_prob_in  = best_prob_ff;
      best_class_in = best_class_ff;
      run_class_in  = run_class_ff;
      run_prob_in   = run_prob_ff;
      emitted_in    = emitted_ff;
      new_run_class = run_class_ff;
      new_run_prob  = run_prob_ff;
      emitted       = emitted_ff;
      ctrl          = '0;
      push_c0_prob  = run_prob_ff;
      push_c1_prob  = run_prob_ff;
      push          = 1'b0;
      if (accept) begin
         if (!req_bus.last_class) begin
            best_prob_in  = nb_prob;
            best_class_in = nb_class;
            if (cnt_ff < CNT_MAX) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end else begin
            if (nb_class_w == run_class_ff) begin
               if (nb_prob > run_prob_ff) begin
                  new_run_prob = nb_prob;
               end
            end else begin
               ctrl.c0_en    = run_class_ff != blank_ff;
               ctrl.c0_class = run_class_ff;
               new_run_class = nb_class_w;
               new_run_prob  = nb_prob;
            end
            cnt_in        = '0;
            best_prob_in  = '0;
            best_class_in = '0;
            emitted       = emitted_ff || ctrl.c0_en;
            if (req_bus.last_step) begin
               ctrl.c1_en    = 1'b1;
               ctrl.c1_mul   = new_run_class != blank_ff;
               ctrl.c1_class = new_run_class;
               push_c1_prob  = new_run_prob;
               ctrl.fin      = 1'b1;
               ctrl.empty    = !(emitted || ctrl.c1_mul);
               if (!ctrl.c1_mul && !ctrl.empty) begin
                  ctrl.c1_en = 1'b0;
               end
               run_class_in = blank_ff;
               run_prob_in  = PROB_ONE;
               emitted_in   = 1'b0;
            end else begin
               run_class_in = new_run_class;
               run_prob_in  = new_run_prob;
               emitted_in   = emitted;
            end
            push = ctrl.c0_en || ctrl.fin;
         end
      end
   end

   assign push_ctrl = ctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ff      <= '0;
         cnt_ff        <= '0;
         best_prob_ff  <= '0;
         best_class_ff <= '0;
         run_class_ff  <= '0;
         run_prob_ff   <= PROB_ONE;
         emitted_ff    <= 1'b0;
      end else if (csr_bus.valid) begin
         blank_ff      <= csr_bus.blank_class;
         cnt_ff        <= '0;
         best_prob_ff  <= '0;
         best_class_ff <= '0;
         run_class_ff  <= csr_bus.blank_class;
         run_prob_ff   <= PROB_ONE;
         emitted_ff    <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         best_prob_ff  <= best_prob_in;
         best_class_ff <= best_class_in;
         run_class_ff  <= run_class_in;
         run_prob_ff   <= run_prob_in;
         emitted_ff    <= emitted_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/ctc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import ctc_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [NW-1:0]    count_ff;

   assign full     = count_ff == NW'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/ctc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctc_back #(
   parameter int PROB_FRAC_BITS = ctc_pkg::PROB_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   q_empty,
   input  ctc_pkg::step_ctrl_type head_ctrl,
   input  logic [PROB_FRAC_BITS:0] head_c0_prob,
   input  logic [PROB_FRAC_BITS:0] head_c1_prob,
   output logic                   pop,
   ctc_rsp_if.source              rsp_bus
);
   import ctc_pkg::*;

   localparam int PW = PROB_FRAC_BITS + 1;
   localparam logic [PW-1:0] PROB_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

   logic               done0_ff, done1_ff;
   logic [PW-1:0]      product_ff;
   logic               valid_ff;
   logic [CLASS_W-1:0] char_ff;
   logic               end_ff;
   logic [PW-1:0]      conf_ff;
   logic               empty_ff;

   logic               load;
   logic               act0, act1;
   logic               more;
   logic [PW-1:0]      mul_prob;
   logic [2*PW-1:0]    mult_full;

   assign act0      = head_ctrl.c0_en && !done0_ff;
   assign act1      = head_ctrl.c1_en && !done1_ff;
   assign load      = !q_empty && (!valid_ff || rsp_bus.ready);
   assign more      = act0 ? (act1 || head_ctrl.fin) : (act1 && head_ctrl.fin);
   assign pop       = load && !more;
   assign mul_prob  = act0 ? head_c0_prob : head_c1_prob;
   assign mult_full = product_ff * mul_prob;

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.char_class  = char_ff;
   assign rsp_bus.is_end      = end_ff;
   assign rsp_bus.confidence  = conf_ff;
   assign rsp_bus.label_empty = empty_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         done0_ff   <= 1'b0;
         done1_ff   <= 1'b0;
         product_ff <= PROB_ONE;
         valid_ff   <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            if (more) begin
               done0_ff <= done0_ff || act0;
               done1_ff <= done1_ff || (!act0 && act1);
            end else begin
               done0_ff <= 1'b0;
               done1_ff <= 1'b0;
            end
            if (act0 || (act1 && head_ctrl.c1_mul)) begin
               product_ff <= mult_full[PROB_FRAC_BITS +: PW];
            end else if (!act0 && !act1) begin
               product_ff <= PROB_ONE;
            end
         end else if (rsp_bus.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (act0) begin
            char_ff  <= head_ctrl.c0_class;
            end_ff   <= 1'b0;
            conf_ff  <= '0;
            empty_ff <= 1'b0;
         end else if (act1) begin
            char_ff  <= head_ctrl.c1_class;
            end_ff   <= 1'b0;
            conf_ff  <= '0;
            empty_ff <= 1'b0;
         end else begin
            char_ff  <= '0;
            end_ff   <= 1'b1;
            conf_ff  <= head_ctrl.empty ? '0 : product_ff;
            empty_ff <= head_ctrl.empty;
         end
      end
   end

endmodule

`default_nettype wire
